FILE: src/wdc_pkg.sv
// Shared types and constants for the weigh-and-dispense controller.
// Holds the item structs, the register indexes and the mode and event codes.
// No dependencies.
package wdc_pkg;

  localparam int MASS_W   = 14;
  localparam int RAW_W    = 24;
  localparam int ECHO_W   = 15;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [MASS_W-1:0] MASS_MAX  = 14'd10000;
  localparam logic [MASS_W-1:0] AVG_RESET = 14'd500;

  // Register reset values.
  localparam logic [15:0] TARGET_MASS_RST = 16'd869;
  localparam logic [14:0] ECHO_LIMIT_RST  = 15'd1166;
  localparam logic [13:0] JAM_LIMIT_RST   = 14'd3000;
  localparam logic [15:0] TIMEOUT_RST     = 16'd600;
  localparam logic [15:0] ERR_HOLD_RST    = 16'd200;
  localparam logic [7:0]  MOTOR_DUTY_RST  = 8'd180;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_MASS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ECHO_LIMIT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_JAM_LIMIT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ERR_HOLD    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_DUTY  = 3'd5;

  // Mode codes on the result channel.
  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_DISP = 2'd1;
  localparam logic [1:0] MODE_ERR  = 2'd2;

  // Event codes on the result channel.
  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_DONE     = 3'd1;
  localparam logic [2:0] EV_JAM_IDLE = 3'd2;
  localparam logic [2:0] EV_JAM_DISP = 3'd3;
  localparam logic [2:0] EV_TIMEOUT  = 3'd4;

  typedef struct packed {
    logic signed [RAW_W-1:0] raw_weight;
    logic                    weight_ready;
    logic [ECHO_W-1:0]       echo_time;
    logic                    schedule_due;
    logic                    manual_start;
    logic                    force_jam;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic [7:0]        motor_drive;
    logic [2:0]        event_res;
    logic [MASS_W-1:0] dispensed_mass;
    logic [MASS_W-1:0] current_mass;
    logic [MASS_W-1:0] consumption_average;
  } out_item_t;

endpackage

FILE: src/wdc_avg.sv
// Consumption average update: (3*d + 7*avg) / 10, truncated.
// Depends on wdc_pkg for the mass width.
module wdc_avg
  import wdc_pkg::*;
(
  input  logic [MASS_W-1:0] disp_mass,
  input  logic [MASS_W-1:0] avg_mass,
  output logic [MASS_W-1:0] avg_next
);

  // Division by ten as a multiply by ceil(2^20/10). The error term stays
  // below one tenth for any sum under 2^18, and the sum peaks at 100000.
  localparam int SUM_W    = 17;
  localparam int SHIFT    = 20;
  localparam logic [SUM_W-1:0] RECIP = 17'd104858;

  logic [SUM_W-1:0]   disp_x3;
  logic [SUM_W-1:0]   avg_x7;
  logic [SUM_W-1:0]   sum;
  logic [2*SUM_W-1:0] prod;

  assign disp_x3  = (SUM_W'(disp_mass) << 1) + SUM_W'(disp_mass);
  assign avg_x7   = (SUM_W'(avg_mass) << 3) - SUM_W'(avg_mass);
  assign sum      = disp_x3 + avg_x7;
  assign prod     = (2*SUM_W)'(sum) * (2*SUM_W)'(RECIP);
  assign avg_next = prod[SHIFT +: MASS_W];

endmodule

FILE: src/weigh_dispense_controller.sv
// Top level of the weigh-and-dispense controller: input register, control
// state machine and result register. Depends on wdc_pkg and wdc_avg.
//
//  channel  | ports                              | moves
//  ---------+------------------------------------+------------------------------
//  input    | in_valid, in_stall, in_data        | one control tick per item
//  result   | out_valid, out_stall, out_data     | one result item per tick
//  config   | cfg_we, cfg_index, cfg_wdata       | one register write per enable
//
// One item per cycle while the result channel is not stalled; an item's result
// reaches the ports through the input register, then the result register, set
// by the single state update.
// Reset is synchronous on rst_n and clears both registers' valid flags and the
// controller state. A stalled result holds in the result register while one
// more item waits in the input register; in_stall rises only when both are full.
module weigh_dispense_controller
  import wdc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_DISP = 2'd1,
    ST_ERR  = 2'd2
  } state_t;

  // Configuration registers.
  logic [15:0] target_mass_r;
  logic [14:0] echo_limit_r;
  logic [13:0] jam_limit_r;
  logic [15:0] timeout_r;
  logic [15:0] err_hold_r;
  logic [7:0]  motor_duty_r;

  // Pipeline and controller state.
  logic        s1_valid_r;
  in_item_t    s1_item_r;
  logic        out_valid_r;
  out_item_t   out_data_r;
  state_t      state_r, state_nxt;
  logic [MASS_W-1:0] latched_r, latched_nxt;
  logic [MASS_W-1:0] start_r, start_nxt;
  logic [MASS_W-1:0] avg_r, avg_nxt;
  logic [15:0] timer_r, timer_nxt;
  logic        jam_r, jam_nxt;

  logic              adv;
  logic [RAW_W-2:0]  raw_half;
  logic [MASS_W-1:0] conv_mass;
  logic [MASS_W-1:0] mass_new;
  logic [MASS_W-1:0] disp_calc;
  logic [MASS_W-1:0] avg_upd;
  logic              pend_eff;
  logic              echo_empty;
  logic              jam;
  logic              start_req;
  out_item_t         res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_mass_r <= TARGET_MASS_RST;
      echo_limit_r  <= ECHO_LIMIT_RST;
      jam_limit_r   <= JAM_LIMIT_RST;
      timeout_r     <= TIMEOUT_RST;
      err_hold_r    <= ERR_HOLD_RST;
      motor_duty_r  <= MOTOR_DUTY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TARGET_MASS: target_mass_r <= cfg_wdata;
        CFG_ECHO_LIMIT:  echo_limit_r  <= cfg_wdata[14:0];
        CFG_JAM_LIMIT:   jam_limit_r   <= cfg_wdata[13:0];
        CFG_TIMEOUT:     timeout_r     <= cfg_wdata;
        CFG_ERR_HOLD:    err_hold_r    <= cfg_wdata;
        CFG_MOTOR_DUTY:  motor_duty_r  <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // The input register advances into the result register whenever the
  // result register is empty or being drained this cycle.
  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && out_valid_r && out_stall;

  // Load-cell count to decigrams: half the count, negatives to zero, clamped.
  assign raw_half  = s1_item_r.raw_weight[RAW_W-1:1];
  assign conv_mass = s1_item_r.raw_weight[RAW_W-1] ? '0 :
                     (raw_half > (RAW_W-1)'(MASS_MAX)) ? MASS_MAX :
                     raw_half[MASS_W-1:0];
  assign mass_new  = s1_item_r.weight_ready ? conv_mass : latched_r;
  assign disp_calc = (start_r > mass_new) ? start_r - mass_new : '0;

  assign pend_eff   = jam_r || s1_item_r.force_jam;
  assign echo_empty = (s1_item_r.echo_time == '0) || (s1_item_r.echo_time > echo_limit_r);
  assign jam        = pend_eff || (echo_empty && (mass_new > jam_limit_r));
  assign start_req  = s1_item_r.schedule_due || s1_item_r.manual_start;

  wdc_avg u_avg (
    .disp_mass (disp_calc),
    .avg_mass  (avg_r),
    .avg_next  (avg_upd)
  );

  always_comb begin
    state_nxt   = state_r;
    latched_nxt = latched_r;
    start_nxt   = start_r;
    avg_nxt     = avg_r;
    timer_nxt   = timer_r;
    jam_nxt     = pend_eff;
    res         = '0;
    res.event_res = EV_NONE;
    case (state_r)
      ST_DISP: begin
        latched_nxt        = mass_new;
        jam_nxt            = 1'b0;
        res.dispensed_mass = disp_calc;
        if (jam) begin
          state_nxt     = ST_ERR;
          timer_nxt     = '0;
          res.event_res = EV_JAM_DISP;
        end else if (16'(disp_calc) >= target_mass_r) begin
          avg_nxt       = avg_upd;
          state_nxt     = ST_IDLE;
          timer_nxt     = '0;
          res.event_res = EV_DONE;
        end else if (timer_r >= timeout_r) begin
          state_nxt     = ST_ERR;
          timer_nxt     = '0;
          res.event_res = EV_TIMEOUT;
        end else begin
          timer_nxt       = timer_r + 16'd1;
          res.motor_drive = motor_duty_r;
        end
      end
      ST_ERR: begin
        if (timer_r >= err_hold_r) begin
          state_nxt = ST_IDLE;
          timer_nxt = '0;
        end else begin
          timer_nxt = timer_r + 16'd1;
        end
      end
      default: begin
        // Idle, and any stray code, which behaves as idle.
        state_nxt   = ST_IDLE;
        latched_nxt = mass_new;
        jam_nxt     = 1'b0;
        if (jam) begin
          state_nxt     = ST_ERR;
          timer_nxt     = '0;
          res.event_res = EV_JAM_IDLE;
        end else if (start_req) begin
          start_nxt = mass_new;
          timer_nxt = '0;
          state_nxt = ST_DISP;
        end
      end
    endcase
    case (state_nxt)
      ST_DISP: res.mode = MODE_DISP;
      ST_ERR:  res.mode = MODE_ERR;
      default: res.mode = MODE_IDLE;
    endcase
    res.current_mass        = latched_nxt;
    res.consumption_average = avg_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= ST_IDLE;
      latched_r   <= '0;
      start_r     <= '0;
      avg_r       <= AVG_RESET;
      timer_r     <= '0;
      jam_r       <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
        if (in_valid) begin
          s1_item_r <= in_data;
        end
      end
      if (adv) begin
        out_valid_r <= 1'b1;
        out_data_r  <= res;
        state_r     <= state_nxt;
        latched_r   <= latched_nxt;
        start_r     <= start_nxt;
        avg_r       <= avg_nxt;
        timer_r     <= timer_nxt;
        jam_r       <= jam_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: src/wdc_checker.sv
// Port-level checks for the weigh-and-dispense controller, bound to the top.
// Depends on wdc_pkg for the item struct and the mode and event codes.
module wdc_checker
  import wdc_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // A stalled result item stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  // The motor only turns on ticks that stay in dispensing.
  a_motor_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.motor_drive != 8'd0) |-> out_data.mode == MODE_DISP)
    else $error("motor driven outside dispensing");

  // Jams and timeouts always leave the block in error.
  a_fault_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.event_res == EV_JAM_IDLE || out_data.event_res == EV_JAM_DISP
                  || out_data.event_res == EV_TIMEOUT) |-> out_data.mode == MODE_ERR)
    else $error("fault event without error mode");

  // A finished portion returns to idle with the motor stopped.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.event_res == EV_DONE)
      |-> out_data.mode == MODE_IDLE && out_data.motor_drive == 8'd0)
    else $error("portion done without returning to idle");

endmodule

bind weigh_dispense_controller wdc_checker u_wdc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
